// ===== hdl/mse_pkg.sv =====
// shared constants, payload types and memory request types for the merge sort engine
package mse_pkg;

    // capacity of one set and derived widths
    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int DATA_W       = 32;

    // result buffer sizing
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    // one input beat
    typedef struct packed {
        logic signed [DATA_W-1:0] value_in;
        logic                     last_in;
    } in_item_t;

    // one result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     last_out;
        logic                     overflow;
    } out_item_t;

    // controller to memories
    typedef struct packed {
        logic              elem_we;
        logic              scr_we;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd0_addr;
        logic [ADDR_W-1:0] rd1_addr;
    } mem_req_t;

    // memories to controller
    typedef struct packed {
        logic [DATA_W-1:0] elem_rd0;
        logic [DATA_W-1:0] elem_rd1;
        logic [DATA_W-1:0] scr_rd0;
        logic [DATA_W-1:0] scr_rd1;
    } mem_rsp_t;

    // controller to result buffer
    typedef struct packed {
        logic      push;
        out_item_t item;
    } obuf_wr_t;

endpackage

// ===== hdl/mse_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
module mse_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [DATA_W-1:0]        rd0_data,
    output logic [DATA_W-1:0]        rd1_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports, registered
    always_ff @(posedge clk)
    begin
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

// ===== hdl/mse_obuf.sv =====
// small result fifo that decouples the emit reads from the receiver's stall
module mse_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  mse_pkg::obuf_wr_t   wr,
    output logic                room,
    output logic                result_valid,
    input  logic                result_stall,
    output mse_pkg::out_item_t  result
);

    mse_pkg::out_item_t                   buf_mem [mse_pkg::OBUF_DEPTH];
    logic [mse_pkg::OBUF_PTR_W-1:0]       head_reg, head_next;
    logic [mse_pkg::OBUF_PTR_W-1:0]       tail_reg, tail_next;
    logic [mse_pkg::OBUF_CNT_W-1:0]       count_reg, count_next;
    logic                                 pop;

    // output side
    assign result_valid = (count_reg != '0);
    assign result       = buf_mem[head_reg];
    assign pop          = result_valid && !result_stall;

    // a read issued now lands next cycle, so count the beat arriving this cycle
    assign room = (count_reg + mse_pkg::OBUF_CNT_W'(wr.push))
                  < mse_pkg::OBUF_CNT_W'(mse_pkg::OBUF_DEPTH);

    // pointer and fill updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (wr.push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        case ({wr.push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            buf_mem[tail_reg] <= wr.item;
        end
    end

    // a beat never arrives at a full buffer unless one leaves in the same cycle
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> (count_reg != mse_pkg::OBUF_CNT_W'(mse_pkg::OBUF_DEPTH)) || pop)
        else $error("result buffer overrun");

endmodule

// ===== hdl/mse_ctrl.sv =====
// load, bottom-up merge pass and emit sequencer around the two data memories
module mse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mse_pkg::in_item_t  item,
    output mse_pkg::mem_req_t  mem_req,
    input  mse_pkg::mem_rsp_t  mem_rsp,
    output mse_pkg::obuf_wr_t  obuf_wr,
    input  logic               room
);

    localparam int CNT_W  = mse_pkg::CNT_W;
    localparam int ADDR_W = mse_pkg::ADDR_W;
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             inflight_reg, inflight_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic             src_reg, src_next;
    logic             rsrc_reg, rsrc_next;
    logic             rlast_reg, rlast_next;
    logic             rovf_reg, rovf_next;

    logic [SUM_W-1:0]           n_w, mid_sum, hi_sum;
    logic [CNT_W-1:0]           mid_c, hi_c, width_dbl;
    logic [mse_pkg::DATA_W-1:0] va, vb;
    logic                       a_act, b_act, take_a;

    // run bounds of the current merge, clipped to the set size
    assign n_w       = {1'b0, count_reg};
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, width_reg};
    assign hi_sum    = {1'b0, lo_reg} + {width_reg, 1'b0};
    assign mid_c     = (mid_sum >= n_w) ? count_reg : mid_sum[CNT_W-1:0];
    assign hi_c      = (hi_sum >= n_w) ? count_reg : hi_sum[CNT_W-1:0];
    assign width_dbl = {width_reg[CNT_W-2:0], 1'b0};

    // heads of both runs from the source memory, left run wins on a tie
    assign va     = src_reg ? mem_rsp.scr_rd0 : mem_rsp.elem_rd0;
    assign vb     = src_reg ? mem_rsp.scr_rd1 : mem_rsp.elem_rd1;
    assign a_act  = (a_reg < mid_reg);
    assign b_act  = (b_reg < hi_reg);
    assign take_a = a_act && (!b_act || ($signed(va) <= $signed(vb)));

    assign item_stall = (state_reg != ST_LOAD);

    // emitted beat: read data arrives in the cycle after the read was issued
    assign obuf_wr.push           = inflight_reg;
    assign obuf_wr.item.value_out = rsrc_reg ? mem_rsp.scr_rd0 : mem_rsp.elem_rd0;
    assign obuf_wr.item.last_out  = rlast_reg;
    assign obuf_wr.item.overflow  = rovf_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        inflight_next = 1'b0;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        emit_next     = emit_reg;
        src_next      = src_reg;
        rsrc_next     = rsrc_reg;
        rlast_next    = rlast_reg;
        rovf_next     = rovf_reg;
        mem_req       = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg < CNT_W'(mse_pkg::MAX_ELEMENTS))
                    begin
                        mem_req.elem_we = 1'b1;
                        mem_req.wr_addr = count_reg[ADDR_W-1:0];
                        mem_req.wr_data = item.value_in;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.last_in)
                    begin
                        width_next = CNT_W'(1);
                        lo_next    = '0;
                        src_next   = 1'b0;
                        emit_next  = '0;
                        if (count_next <= CNT_W'(1))
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_PRIME;
                        end
                    end
                end
            end

            ST_PRIME:
            begin
                mem_req.rd0_addr = lo_reg[ADDR_W-1:0];
                mem_req.rd1_addr = mid_c[ADDR_W-1:0];
                a_next           = lo_reg;
                b_next           = mid_c;
                k_next           = lo_reg;
                mid_next         = mid_c;
                hi_next          = hi_c;
                state_next       = ST_MERGE;
            end

            ST_MERGE:
            begin
                mem_req.wr_addr = k_reg[ADDR_W-1:0];
                mem_req.wr_data = take_a ? va : vb;
                mem_req.elem_we = src_reg;
                mem_req.scr_we  = !src_reg;
                if (take_a)
                begin
                    a_next = a_reg + CNT_W'(1);
                end
                else
                begin
                    b_next = b_reg + CNT_W'(1);
                end
                mem_req.rd0_addr = a_next[ADDR_W-1:0];
                mem_req.rd1_addr = b_next[ADDR_W-1:0];
                k_next           = k_reg + CNT_W'(1);
                // end of this merge: next pair of runs, next pass, or emit once the set is sorted
                if (k_next == hi_reg)
                begin
                    if (hi_sum >= n_w)
                    begin
                        width_next = width_dbl;
                        src_next   = !src_reg;
                        lo_next    = '0;
                        if (width_dbl >= count_reg)
                        begin
                            emit_next  = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_PRIME;
                        end
                    end
                    else
                    begin
                        lo_next    = hi_sum[CNT_W-1:0];
                        state_next = ST_PRIME;
                    end
                end
            end

            ST_EMIT:
            begin
                if (room)
                begin
                    mem_req.rd0_addr = emit_reg[ADDR_W-1:0];
                    inflight_next    = 1'b1;
                    rsrc_next        = src_reg;
                    rovf_next        = dropped_reg;
                    rlast_next       = ((emit_reg + CNT_W'(1)) == count_reg);
                    emit_next        = emit_reg + CNT_W'(1);
                    if ((emit_reg + CNT_W'(1)) == count_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            inflight_reg <= inflight_next;
        end
    end

    // pointers and beat attributes
    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        emit_reg  <= emit_next;
        src_reg   <= src_next;
        rsrc_reg  <= rsrc_next;
        rlast_reg <= rlast_next;
        rovf_reg  <= rovf_next;
    end

    // merge pointers stay inside their runs
    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE |-> (k_reg < hi_reg) && (a_reg <= mid_reg) && (b_reg <= hi_reg))
        else $error("merge pointer out of run");

    // every written slot consumed exactly one head from either run
    a_merge_progress: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE |->
            ({1'b0, k_reg} + {1'b0, mid_reg}) == ({1'b0, a_reg} + {1'b0, b_reg}))
        else $error("merge output index out of step with run heads");

    // a set being sorted or emitted is never empty and never above capacity
    a_set_size: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |->
            (count_reg != '0) && (count_reg <= CNT_W'(mse_pkg::MAX_ELEMENTS)))
        else $error("set size out of range");

    // result beats only follow an emit read
    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg |-> $past(state_reg) == ST_EMIT)
        else $error("result beat without emit read");

endmodule

// ===== hdl/merge_sort_engine.sv =====
// top level of the merge sort engine: controller, element and scratch rams, result buffer
//
// Usage: values arrive as beats on the item channel (item_valid / item_stall / item).
// Each beat stores one signed value; the beat with last_in set closes the set.
// While loading, one beat is taken per cycle. Beats beyond the 64-entry capacity
// are discarded and the run that follows carries overflow on every beat.
// Once the set is closed, item_stall stays high while the set is sorted and read out.
// The sort runs bottom-up merge passes that ping-pong between the element ram and
// the scratch ram, one merged element per cycle from the dual read ports, plus a
// priming step before each pair of runs.
// The sorted run then leaves on the result channel (result_valid / result_stall /
// result), one beat per cycle unless stalled, last_out on its final beat; a four-entry
// buffer holds beats while the receiver stalls and pauses the ram reads when it fills.
// The first result follows the sort through the ram read register and the buffer.
// Loading of the next set may begin as soon as the last read is issued.
// Reset (rst_n low, asynchronous) empties the set, the overflow flag and the buffer.
module merge_sort_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mse_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output mse_pkg::out_item_t result
);

    mse_pkg::mem_req_t mem_req;
    mse_pkg::mem_rsp_t mem_rsp;
    mse_pkg::obuf_wr_t obuf_wr;
    logic              room;

    // sequencer
    mse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp),
        .obuf_wr    (obuf_wr),
        .room       (room)
    );

    // element ram, loaded with the set
    mse_ram #(
        .DATA_W (mse_pkg::DATA_W),
        .DEPTH  (mse_pkg::MAX_ELEMENTS)
    ) u_elem_ram (
        .clk      (clk),
        .we       (mem_req.elem_we),
        .wr_addr  (mem_req.wr_addr),
        .wr_data  (mem_req.wr_data),
        .rd0_addr (mem_req.rd0_addr),
        .rd1_addr (mem_req.rd1_addr),
        .rd0_data (mem_rsp.elem_rd0),
        .rd1_data (mem_rsp.elem_rd1)
    );

    // scratch ram, the other half of each merge pass
    mse_ram #(
        .DATA_W (mse_pkg::DATA_W),
        .DEPTH  (mse_pkg::MAX_ELEMENTS)
    ) u_scr_ram (
        .clk      (clk),
        .we       (mem_req.scr_we),
        .wr_addr  (mem_req.wr_addr),
        .wr_data  (mem_req.wr_data),
        .rd0_addr (mem_req.rd0_addr),
        .rd1_addr (mem_req.rd1_addr),
        .rd0_data (mem_rsp.scr_rd0),
        .rd1_data (mem_rsp.scr_rd1)
    );

    // result buffer
    mse_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (obuf_wr),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
